// File: hw/rtl/eidu_pkg.sv
`default_nettype none
// eidu_pkg: shared types and constants for the e-ink index diff update block.
// Used by eidu_lane, eidu_merge and eink_index_diff_update_top; no dependencies.

package eidu_pkg;

    // Coordinate width default, pixel layout of one 32-bit word
    localparam int COORD_BITS_DEF = 12;
    localparam int NUM_LANES      = 4;
    localparam int PIX_BITS       = 8;
    localparam int NIB_BITS       = 4;
    localparam int WORD_BITS      = NUM_LANES * PIX_BITS;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IDX_REVERSE = 1'b0;

    // Status codes reported on the last word of an area
    localparam logic [1:0] STATUS_NONE = 2'd0;
    localparam logic [1:0] STATUS_BW   = 2'd1;
    localparam logic [1:0] STATUS_GRAY = 2'd2;

    // Per-pixel findings handed from a lane to the merge stage
    typedef struct packed {
        logic changed;
        logic gray;
    } lane_flag_t;

endpackage

`default_nettype wire

// File: hw/rtl/eidu_lane.sv
`default_nettype none
// eidu_lane: one pixel lane; builds the new index byte and flags change and gray.
// Depends on eidu_pkg.

module eidu_lane (
    input  wire logic [eidu_pkg::PIX_BITS-1:0] fb_pix,
    input  wire logic [eidu_pkg::PIX_BITS-1:0] idx_pix,
    output logic [eidu_pkg::PIX_BITS-1:0]      new_idx_pix,
    output eidu_pkg::lane_flag_t               flags
);
    import eidu_pkg::*;

    logic [NIB_BITS-1:0] cur_nib;
    logic [NIB_BITS-1:0] prev_nib;

    always_comb begin
        cur_nib       = fb_pix[PIX_BITS-1:NIB_BITS];
        prev_nib      = idx_pix[NIB_BITS-1:0];
        new_idx_pix   = {prev_nib, cur_nib};
        flags.changed = (cur_nib != prev_nib);
        // gray: any level other than full black or full white
        flags.gray    = (cur_nib != '0) && (cur_nib != '1);
    end

endmodule

`default_nettype wire

// File: hw/rtl/eidu_merge.sv
`default_nettype none
// eidu_merge: combines lane flags, tracks change/gray and the changed and whole-area boxes,
// and forms status and box for the last word. Depends on eidu_pkg.

module eidu_merge #(
    parameter int COORD_BITS = eidu_pkg::COORD_BITS_DEF
) (
    input  wire logic                                          aclk,
    input  wire logic                                          aresetn,
    input  wire logic                                          accept,
    input  wire eidu_pkg::lane_flag_t [eidu_pkg::NUM_LANES-1:0] lane_flags,
    input  wire logic [COORD_BITS-1:0]                         pix_x,
    input  wire logic [COORD_BITS-1:0]                         pix_y,
    input  wire logic                                          full_update,
    input  wire logic                                          last_word,
    output logic [1:0]                                         status,
    output logic [COORD_BITS-1:0]                              box_left,
    output logic [COORD_BITS-1:0]                              box_top,
    output logic [COORD_BITS-1:0]                              box_right,
    output logic [COORD_BITS-1:0]                              box_bottom
);
    import eidu_pkg::*;

    localparam logic [COORD_BITS-1:0] ALIGN_LOW = COORD_BITS'(3);
    localparam logic [COORD_BITS:0]   SPAN_WIDE = (COORD_BITS + 1)'(3);

    logic                  change_seen_reg, change_seen_next;
    logic                  gray_seen_reg, gray_seen_next;
    logic [COORD_BITS-1:0] min_cx_reg, min_cx_next;
    logic [COORD_BITS-1:0] max_cx_reg, max_cx_next;
    logic [COORD_BITS-1:0] min_cy_reg, min_cy_next;
    logic [COORD_BITS-1:0] max_cy_reg, max_cy_next;
    logic [COORD_BITS-1:0] min_ax_reg, min_ax_next;
    logic [COORD_BITS-1:0] max_ax_reg, max_ax_next;
    logic [COORD_BITS-1:0] min_ay_reg, min_ay_next;
    logic [COORD_BITS-1:0] max_ay_reg, max_ay_next;

    logic                  any_change;
    logic                  any_gray;
    logic [COORD_BITS:0]   right_wide;

    always_comb begin
        any_change = 1'b0;
        any_gray   = 1'b0;
        for (int i = 0; i < NUM_LANES; i++) begin
            any_change = any_change | lane_flags[i].changed;
            any_gray   = any_gray | lane_flags[i].gray;
        end

        // state including the current word
        change_seen_next = change_seen_reg | any_change;
        gray_seen_next   = gray_seen_reg | any_gray;
        min_cx_next = (any_change && (pix_x < min_cx_reg)) ? pix_x : min_cx_reg;
        max_cx_next = (any_change && (pix_x > max_cx_reg)) ? pix_x : max_cx_reg;
        min_cy_next = (any_change && (pix_y < min_cy_reg)) ? pix_y : min_cy_reg;
        max_cy_next = (any_change && (pix_y > max_cy_reg)) ? pix_y : max_cy_reg;
        min_ax_next = (pix_x < min_ax_reg) ? pix_x : min_ax_reg;
        max_ax_next = (pix_x > max_ax_reg) ? pix_x : max_ax_reg;
        min_ay_next = (pix_y < min_ay_reg) ? pix_y : min_ay_reg;
        max_ay_next = (pix_y > max_ay_reg) ? pix_y : max_ay_reg;

        right_wide = ({1'b0, max_cx_next} + SPAN_WIDE) | SPAN_WIDE;

        status     = STATUS_NONE;
        box_left   = '0;
        box_top    = '0;
        box_right  = '0;
        box_bottom = '0;
        if (last_word) begin
            if (full_update) begin
                status     = gray_seen_next ? STATUS_GRAY : STATUS_BW;
                box_left   = min_ax_next;
                box_top    = min_ay_next;
                box_right  = max_ax_next | ALIGN_LOW;
                box_bottom = max_ay_next;
            end else if (change_seen_next) begin
                status     = gray_seen_next ? STATUS_GRAY : STATUS_BW;
                box_left   = min_cx_next & ~ALIGN_LOW;
                box_top    = min_cy_next & ~ALIGN_LOW;
                // saturate when the aligned right edge leaves the coordinate range
                box_right  = right_wide[COORD_BITS] ? '1 : right_wide[COORD_BITS-1:0];
                box_bottom = max_cy_next | ALIGN_LOW;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && last_word)) begin
            change_seen_reg <= 1'b0;
            gray_seen_reg   <= 1'b0;
            min_cx_reg      <= '1;
            max_cx_reg      <= '0;
            min_cy_reg      <= '1;
            max_cy_reg      <= '0;
            min_ax_reg      <= '1;
            max_ax_reg      <= '0;
            min_ay_reg      <= '1;
            max_ay_reg      <= '0;
        end else if (accept) begin
            change_seen_reg <= change_seen_next;
            gray_seen_reg   <= gray_seen_next;
            min_cx_reg      <= min_cx_next;
            max_cx_reg      <= max_cx_next;
            min_cy_reg      <= min_cy_next;
            max_cy_reg      <= max_cy_next;
            min_ax_reg      <= min_ax_next;
            max_ax_reg      <= max_ax_next;
            min_ay_reg      <= min_ay_next;
            max_ay_reg      <= max_ay_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/eink_index_diff_update_top.sv
`default_nettype none
// eink_index_diff_update_top: stream top level with APB register, four pixel lanes,
// merge/box tracker and a two-entry output buffer. Depends on eidu_pkg, eidu_lane, eidu_merge.

// Takes one framebuffer/index word pair per transaction and returns one result
// transaction per input. Each word carries four pixels that are handled by four
// lanes side by side; a merge stage folds their change and gray flags into the
// area state and the changed-box tracker. A word is taken every clock cycle
// while the skid entry is empty: the result is registered, and a register
// plus a skid entry on the output keep the input side open for one more
// word while a result waits on m_tready. The input stays closed while the
// skid entry holds a result, until it advances into the result register.
// Throughput is one word per cycle when the output does not stall, set by the
// single stage of lane logic, min/max compare and box forming. On the
// transaction with s_tlast set the result carries m_tlast, the status and the
// box, and the area state is cleared for the next area.
// Register 0 (byte address 0, bit 0): reverse_bytes, byte-reverse each
// framebuffer word for an upside-down panel. Write it only while the block is idle.

module eink_index_diff_update_top #(
    parameter int COORD_BITS = eidu_pkg::COORD_BITS_DEF,
    parameter int S_DATA_W   = ((2 * eidu_pkg::WORD_BITS + 2 * COORD_BITS + 7) / 8) * 8,
    parameter int M_DATA_W   = ((eidu_pkg::WORD_BITS + 2 + 4 * COORD_BITS + 7) / 8) * 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // APB configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [eidu_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [eidu_pkg::APB_DATA_W-1:0] pwdata,
    output logic [eidu_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata, low bit up: fb_word, idx_word, pix_x, pix_y, zero fill
    input  wire logic [S_DATA_W-1:0]             s_tdata,
    // s_tuser: full_update
    input  wire logic [0:0]                      s_tuser,
    input  wire logic                            s_tlast,
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata, low bit up: new_idx_word, status, box_left, box_top, box_right,
    // box_bottom, zero fill
    output logic [M_DATA_W-1:0]                  m_tdata,
    output logic                                 m_tlast
);
    import eidu_pkg::*;

    localparam int X_LO   = 2 * WORD_BITS;
    localparam int Y_LO   = X_LO + COORD_BITS;
    localparam int RES_W  = WORD_BITS + 2 + 4 * COORD_BITS;

    // configuration
    logic reverse_bytes_reg;

    // input fields
    logic [WORD_BITS-1:0]  fb_word;
    logic [WORD_BITS-1:0]  fb_used;
    logic [WORD_BITS-1:0]  idx_word;
    logic [COORD_BITS-1:0] pix_x;
    logic [COORD_BITS-1:0] pix_y;
    logic                  in_accept;

    // lane and merge results
    logic [WORD_BITS-1:0]                new_idx_word;
    lane_flag_t [NUM_LANES-1:0]          lane_flags;
    logic [1:0]                          status;
    logic [COORD_BITS-1:0]               box_left, box_top, box_right, box_bottom;
    logic [RES_W-1:0]                    res_pack;
    logic [M_DATA_W-1:0]                 res_data;

    // output buffer: result register plus skid entry
    logic                out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;
    logic                out_last_reg, out_last_next;
    logic                skid_valid_reg, skid_valid_next;
    logic [M_DATA_W-1:0] skid_data_reg, skid_data_next;
    logic                skid_last_reg, skid_last_next;

    // ---------------------------------------------------------------
    // APB register: write on the access phase, read back bit 0
    // ---------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reverse_bytes_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && (paddr[APB_ADDR_W-1] == REG_IDX_REVERSE)) begin
            reverse_bytes_reg <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1] == REG_IDX_REVERSE) begin
            prdata[0] = reverse_bytes_reg;
        end
    end

    // ---------------------------------------------------------------
    // Unpack the input transaction, byte-reverse when configured
    // ---------------------------------------------------------------
    assign fb_word   = s_tdata[WORD_BITS-1:0];
    assign idx_word  = s_tdata[2*WORD_BITS-1:WORD_BITS];
    assign pix_x     = s_tdata[X_LO+COORD_BITS-1:X_LO];
    assign pix_y     = s_tdata[Y_LO+COORD_BITS-1:Y_LO];
    assign in_accept = s_tvalid && s_tready;

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            fb_used[i*PIX_BITS +: PIX_BITS] = reverse_bytes_reg
                ? fb_word[(NUM_LANES-1-i)*PIX_BITS +: PIX_BITS]
                : fb_word[i*PIX_BITS +: PIX_BITS];
        end
    end

    // ---------------------------------------------------------------
    // Pixel lanes, one per byte
    // ---------------------------------------------------------------
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        eidu_lane u_lane (
            .fb_pix      (fb_used[g*PIX_BITS +: PIX_BITS]),
            .idx_pix     (idx_word[g*PIX_BITS +: PIX_BITS]),
            .new_idx_pix (new_idx_word[g*PIX_BITS +: PIX_BITS]),
            .flags       (lane_flags[g])
        );
    end

    // ---------------------------------------------------------------
    // Merge lanes, track the area, form status and box
    // ---------------------------------------------------------------
    eidu_merge #(
        .COORD_BITS (COORD_BITS)
    ) u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (in_accept),
        .lane_flags  (lane_flags),
        .pix_x       (pix_x),
        .pix_y       (pix_y),
        .full_update (s_tuser[0]),
        .last_word   (s_tlast),
        .status      (status),
        .box_left    (box_left),
        .box_top     (box_top),
        .box_right   (box_right),
        .box_bottom  (box_bottom)
    );

    assign res_pack = {box_bottom, box_right, box_top, box_left, status, new_idx_word};
    assign res_data = M_DATA_W'(res_pack);

    // ---------------------------------------------------------------
    // Output buffer: hold a stalled result, park the next one in the skid
    // entry, refill the result register from the skid entry first
    // ---------------------------------------------------------------
    assign s_tready = !skid_valid_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_last_next  = skid_last_reg;

        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                // advance the parked result; input is closed this cycle
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                out_last_next   = skid_last_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_accept;
                out_data_next  = res_data;
                out_last_next  = s_tlast;
            end
        end else if (in_accept) begin
            // result register is stalled: park the new result
            skid_valid_next = 1'b1;
            skid_data_next  = res_data;
            skid_last_next  = s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
        skid_data_reg <= skid_data_next;
        skid_last_reg <= skid_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire
